>>> rtl/core/svfd_pkg.sv
// ----------------------------------------------------------------------------
// svfd_pkg
// Shared types and constants of the sync / varint-length frame deframer.
// ----------------------------------------------------------------------------
package svfd_pkg;

	localparam logic [7:0] SYNC_BYTE        = 8'hBB;
	localparam int         MAX_LENGTH_BYTES = 4;
	localparam int         COUNT_WIDTH      = 16;
	localparam int         LEN_W            = 28;
	localparam int         LBC_W            = 3;
	localparam int         Q_DEPTH          = 4;
	localparam int         Q_PTR_W          = 2;
	localparam int         Q_CNT_W          = 3;
	localparam int         OUT_TDATA_W      = 64;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	typedef enum logic [3:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_TYPE,
		PH_LEN,
		PH_VER,
		PH_TLH,
		PH_TLL,
		PH_TOPIC,
		PH_MIDH,
		PH_MIDL,
		PH_PAYLOAD,
		PH_DISCARD
	} svfd_phase_t;

	typedef enum logic [1:0] {
		KIND_TOPIC   = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ACCEPT  = 2'd2,
		KIND_REJECT  = 2'd3
	} svfd_kind_t;

	// one queued event: an optional data byte and an optional end-of-buffer status
	typedef struct packed {
		logic        dat_vld;
		logic        dat_pay;
		logic [7:0]  dat;
		logic        sts_vld;
		logic        sts_ok;
		logic [7:0]  frame_type;
		logic [7:0]  version;
		logic [15:0] message_id;
		logic [7:0]  topic_length;
		logic [15:0] payload_length;
	} svfd_evt_t;

endpackage

>>> rtl/core/svfd_front.sv
// ----------------------------------------------------------------------------
// svfd_front
// Byte parser: tracks the frame phase and turns topic/payload bytes and buffer ends into queue events.
// ----------------------------------------------------------------------------
module svfd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic                in_eob,
	output logic                in_ready,
	output logic                evt_valid,
	output svfd_pkg::svfd_evt_t evt,
	input  logic                evt_ready
);
	import svfd_pkg::*;

	svfd_phase_t            phase_q, phase_n;
	logic [LEN_W-1:0]       decl_q, decl_n;
	logic [LBC_W-1:0]       lbc_q, lbc_n;
	logic [COUNT_WIDTH-1:0] body_q, body_n;
	logic [7:0]             tlen_q, tlen_n;
	logic [7:0]             tleft_q, tleft_n;
	logic [15:0]            mid_q, mid_n;
	logic [7:0]             ver_q, ver_n;
	logic [7:0]             ftype_q, ftype_n;
	logic                   rej_q, rej_n;
	logic                   dat_vld, dat_pay;
	logic                   acc;

	assign in_ready = evt_ready;
	assign acc      = in_valid && in_ready;

	// next state
	always_comb begin
		phase_n = phase_q;
		decl_n  = decl_q;
		lbc_n   = lbc_q;
		body_n  = body_q;
		tlen_n  = tlen_q;
		tleft_n = tleft_q;
		mid_n   = mid_q;
		ver_n   = ver_q;
		ftype_n = ftype_q;
		rej_n   = rej_q;
		dat_vld = 1'b0;
		dat_pay = 1'b0;
		unique case (phase_q)
			PH_SYNC1: begin
				if (in_byte == SYNC_BYTE) begin
					phase_n = PH_SYNC2;
				end else begin
					rej_n   = 1'b1;
					phase_n = PH_DISCARD;
				end
			end
			PH_SYNC2: begin
				if (in_byte == SYNC_BYTE) begin
					phase_n = PH_TYPE;
				end else begin
					rej_n   = 1'b1;
					phase_n = PH_DISCARD;
				end
			end
			PH_TYPE: begin
				ftype_n = in_byte;
				decl_n  = '0;
				lbc_n   = '0;
				phase_n = PH_LEN;
			end
			PH_LEN: begin
				decl_n = {decl_q[LEN_W-8:0], in_byte[6:0]};
				lbc_n  = lbc_q + LBC_W'(1);
				if (!in_byte[7]) begin
					body_n  = '0;
					phase_n = PH_VER;
				end else if (lbc_n >= LBC_W'(MAX_LENGTH_BYTES)) begin
					rej_n   = 1'b1;
					phase_n = PH_DISCARD;
				end
			end
			PH_DISCARD: begin
			end
			default: begin
				if ((phase_q == PH_PAYLOAD && LEN_W'(body_q) >= decl_q) ||
				    body_q == CNT_MAX) begin
					rej_n   = 1'b1;
					phase_n = PH_DISCARD;
				end else begin
					body_n = body_q + COUNT_WIDTH'(1);
					unique case (phase_q)
						PH_VER: begin
							ver_n   = in_byte;
							phase_n = PH_TLH;
						end
						PH_TLH: phase_n = PH_TLL;
						PH_TLL: begin
							tlen_n = in_byte;
							if (LEN_W'(in_byte) + LEN_W'(5) > decl_q) begin
								rej_n   = 1'b1;
								phase_n = PH_DISCARD;
							end else begin
								tleft_n = in_byte;
								phase_n = (in_byte != 8'd0) ? PH_TOPIC : PH_MIDH;
							end
						end
						PH_TOPIC: begin
							dat_vld = 1'b1;
							tleft_n = tleft_q - 8'd1;
							if (tleft_n == 8'd0) phase_n = PH_MIDH;
						end
						PH_MIDH: begin
							mid_n   = {in_byte, 8'h00};
							phase_n = PH_MIDL;
						end
						PH_MIDL: begin
							mid_n   = {mid_q[15:8], in_byte};
							phase_n = PH_PAYLOAD;
						end
						PH_PAYLOAD: begin
							dat_vld = 1'b1;
							dat_pay = 1'b1;
						end
						default: begin
							rej_n   = 1'b1;
							phase_n = PH_DISCARD;
						end
					endcase
				end
			end
		endcase
	end

	// event out
	always_comb begin
		evt_valid          = acc && (dat_vld || in_eob);
		evt.dat_vld        = dat_vld;
		evt.dat_pay        = dat_pay;
		evt.dat            = in_byte;
		evt.sts_vld        = in_eob;
		evt.sts_ok         = !rej_n && phase_n == PH_PAYLOAD && LEN_W'(body_n) == decl_n;
		evt.frame_type     = ftype_n;
		evt.version        = ver_n;
		evt.message_id     = mid_n;
		evt.topic_length   = tlen_n;
		evt.payload_length = decl_n[15:0] - 16'd5 - {8'd0, tlen_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			decl_q  <= '0;
			lbc_q   <= '0;
			body_q  <= '0;
			tlen_q  <= '0;
			tleft_q <= '0;
			mid_q   <= '0;
			ver_q   <= '0;
			ftype_q <= '0;
			rej_q   <= 1'b0;
		end else if (acc) begin
			if (in_eob) begin
				phase_q <= PH_SYNC1;
				decl_q  <= '0;
				lbc_q   <= '0;
				body_q  <= '0;
				tlen_q  <= '0;
				tleft_q <= '0;
				mid_q   <= '0;
				ver_q   <= '0;
				ftype_q <= '0;
				rej_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				decl_q  <= decl_n;
				lbc_q   <= lbc_n;
				body_q  <= body_n;
				tlen_q  <= tlen_n;
				tleft_q <= tleft_n;
				mid_q   <= mid_n;
				ver_q   <= ver_n;
				ftype_q <= ftype_n;
				rej_q   <= rej_n;
			end
		end
	end

	a_eob_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_eob) |=> (phase_q == PH_SYNC1 && !rej_q))
		else $error("front not back in sync search after end of buffer");

	a_discard_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DISCARD) |-> rej_q)
		else $error("discard phase without reject flag");

endmodule

>>> rtl/core/svfd_queue.sv
// ----------------------------------------------------------------------------
// svfd_queue
// Small event FIFO between parser and result sender.
// ----------------------------------------------------------------------------
module svfd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  svfd_pkg::svfd_evt_t in_evt,
	output logic                in_ready,
	output logic                out_valid,
	output svfd_pkg::svfd_evt_t out_evt,
	input  logic                out_ready
);
	import svfd_pkg::*;

	svfd_evt_t            mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_q, rd_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 push, pop;

	assign in_ready  = cnt_q != Q_CNT_W'(Q_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_evt   = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_evt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + Q_PTR_W'(1);
			if (pop) rd_q <= rd_q + Q_PTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + Q_CNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - Q_CNT_W'(1);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count above depth");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == Q_CNT_W'(Q_DEPTH)) |-> (wr_q == rd_q))
		else $error("queue pointers disagree with count");

endmodule

>>> rtl/core/svfd_back.sv
// ----------------------------------------------------------------------------
// svfd_back
// Result sender: expands each event into one or two results on an output register.
// ----------------------------------------------------------------------------
module svfd_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           evt_valid,
	input  svfd_pkg::svfd_evt_t            evt,
	output logic                           evt_ready,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [svfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]                     m_axis_tuser,
	output logic                           m_axis_tlast
);
	import svfd_pkg::*;

	logic                   vld_q;
	logic [OUT_TDATA_W-1:0] tdata_q, tdata_n;
	svfd_kind_t             kind_q, kind_n;
	logic                   last_q;
	logic                   sent_q;
	logic                   load, emit_dat;

	assign load      = evt_valid && (!vld_q || m_axis_tready);
	assign emit_dat  = evt.dat_vld && !sent_q;
	assign evt_ready = load && (!emit_dat || !evt.sts_vld);

	always_comb begin
		if (emit_dat) begin
			kind_n  = evt.dat_pay ? KIND_PAYLOAD : KIND_TOPIC;
			tdata_n = {evt.payload_length, evt.topic_length,
			           evt.dat_pay ? evt.message_id : 16'd0,
			           evt.version, evt.frame_type, evt.dat};
		end else if (evt.sts_ok) begin
			kind_n  = KIND_ACCEPT;
			tdata_n = {evt.payload_length, evt.topic_length, evt.message_id,
			           evt.version, evt.frame_type, 8'd0};
		end else begin
			kind_n  = KIND_REJECT;
			tdata_n = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tdata_q <= tdata_n;
			kind_q  <= kind_n;
			last_q  <= !emit_dat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			sent_q <= 1'b0;
		end else begin
			if (load) vld_q <= 1'b1;
			else if (m_axis_tready) vld_q <= 1'b0;
			if (load) sent_q <= emit_dat && evt.sts_vld;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = kind_q;
	assign m_axis_tlast  = last_q;

	a_sent_pending: assert property (@(posedge clk) disable iff (!arst_n)
		sent_q |-> (evt_valid && evt.sts_vld && evt.dat_vld))
		else $error("data sent flag without pending status");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> (last_q == (kind_q == KIND_ACCEPT || kind_q == KIND_REJECT)))
		else $error("last mark does not match result kind");

endmodule

>>> rtl/core/sync_varlen_frame_deframer.sv
// ----------------------------------------------------------------------------
// sync_varlen_frame_deframer
// Sync / varint-length frame deframer: passes topic and payload bytes and
// closes each buffer with an accepted or rejected status.
//
// Channel  Dir  tdata (low bit up)                           tuser  tlast
// s_axis   in   data_byte[7:0]                               -      end_of_buffer
// m_axis   out  data, frame_type, version, message_id,       kind   last
//               topic_length, payload_length
//
// One byte accepted per cycle while the event queue has room; the parser handles it in that cycle.
// A byte that gives a data result and closes the buffer yields two output
// results; the 4-entry event queue absorbs these bursts.
// No clearing pass: the block accepts bytes as soon as reset is released.
// Input stalls only while the event queue is full.
// ----------------------------------------------------------------------------
module sync_varlen_frame_deframer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // data_byte
	input  logic                             s_axis_tlast,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// data, frame_type, version, message_id, topic_length, payload_length
	output logic [svfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]                       m_axis_tuser,  // kind
	output logic                             m_axis_tlast
);
	import svfd_pkg::*;

	svfd_evt_t f_evt, q_evt;
	logic      f_vld, f_rdy, q_vld, q_rdy;

	svfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_byte   (s_axis_tdata),
		.in_eob    (s_axis_tlast),
		.in_ready  (s_axis_tready),
		.evt_valid (f_vld),
		.evt       (f_evt),
		.evt_ready (f_rdy)
	);

	svfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_vld),
		.in_evt    (f_evt),
		.in_ready  (f_rdy),
		.out_valid (q_vld),
		.out_evt   (q_evt),
		.out_ready (q_rdy)
	);

	svfd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.evt_valid     (q_vld),
		.evt           (q_evt),
		.evt_ready     (q_rdy),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

>>> test/tb_sync_varlen_frame_deframer.sv
// ----------------------------------------------------------------------------
// tb_sync_varlen_frame_deframer
// Self-checking bench for the sync / varint-length frame deframer. Byte
// buffers are streamed in through the slave port, and each output
// transaction is compared field by field against an in-bench parser that
// tracks the same frame state. Directed buffers cover well-formed frames and
// sync, length and body rejections. Random traffic mixes valid frames with
// truncated, corrupted and noisy buffers, with random stalls on both ports.
// ----------------------------------------------------------------------------
module tb_sync_varlen_frame_deframer;

	timeunit 1ns;
	timeprecision 1ps;

	import svfd_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		svfd_kind_t  kind;
		logic [7:0]  data;
		logic [7:0]  frame_type;
		logic [7:0]  version;
		logic [15:0] message_id;
		logic [7:0]  topic_length;
		logic [15:0] payload_length;
		logic        last;
	} deframed_t;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        byte_valid = 1'b0;
	logic [7:0]  byte_data  = 8'h00;
	logic        byte_last  = 1'b0;
	logic        out_ready  = 1'b0;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// parser state
	svfd_phase_t            ph;
	logic [LEN_W-1:0]       decl_len;
	logic [LBC_W-1:0]       len_cnt;
	logic [COUNT_WIDTH-1:0] body_cnt;
	logic [7:0]             topic_bytes;
	logic [7:0]             topic_left;
	logic [15:0]            msg_id;
	logic [7:0]             version;
	logic [7:0]             ftype;
	bit                     rejected;

	deframed_t  deframed_q[$];
	logic [7:0] rx_buf[$];
	int         mismatches   = 0;
	int         quiet_cycles = 0;
	int         bytes_sent   = 0;
	bit         source_gaps  = 1'b1;
	bit         sink_stalls  = 1'b1;
	bit         hold_request = 1'b0;

	sync_varlen_frame_deframer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (byte_valid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (byte_data),
		.s_axis_tlast  (byte_last),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (out_ready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void reset_parser();
		ph          = PH_SYNC1;
		decl_len    = '0;
		len_cnt     = '0;
		body_cnt    = '0;
		topic_bytes = 8'h00;
		topic_left  = 8'h00;
		msg_id      = 16'h0000;
		version     = 8'h00;
		ftype       = 8'h00;
		rejected    = 1'b0;
	endfunction

	function automatic void abandon_frame();
		rejected = 1'b1;
		ph       = PH_DISCARD;
	endfunction

	function automatic void push_deframed(input svfd_kind_t k, input logic [7:0] d,
			input bit hdr, input bit with_id, input bit closes);
		deframed_t r;
		r.kind           = k;
		r.data           = d;
		r.frame_type     = hdr ? ftype : 8'h00;
		r.version        = hdr ? version : 8'h00;
		r.message_id     = (hdr && with_id) ? msg_id : 16'h0000;
		r.topic_length   = hdr ? topic_bytes : 8'h00;
		r.payload_length = hdr ? (decl_len[15:0] - 16'd5 - {8'h00, topic_bytes}) : 16'h0000;
		r.last           = closes;
		deframed_q.push_back(r);
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic eob);
		case (ph)
			PH_SYNC1: begin
				if (b == SYNC_BYTE) ph = PH_SYNC2;
				else abandon_frame();
			end
			PH_SYNC2: begin
				if (b == SYNC_BYTE) ph = PH_TYPE;
				else abandon_frame();
			end
			PH_TYPE: begin
				ftype    = b;
				decl_len = '0;
				len_cnt  = '0;
				ph       = PH_LEN;
			end
			PH_LEN: begin
				decl_len = {decl_len[LEN_W-8:0], b[6:0]};
				len_cnt  = len_cnt + 1'b1;
				if (!b[7]) begin
					body_cnt = '0;
					ph       = PH_VER;
				end else if (len_cnt >= MAX_LENGTH_BYTES) begin
					abandon_frame();
				end
			end
			PH_DISCARD: begin
			end
			default: begin
				if (ph == PH_PAYLOAD && body_cnt >= decl_len) begin
					abandon_frame();
				end else if (body_cnt >= CNT_MAX) begin
					abandon_frame();
				end else begin
					body_cnt = body_cnt + 1'b1;
					case (ph)
						PH_VER: begin
							version = b;
							ph      = PH_TLH;
						end
						PH_TLH: ph = PH_TLL;
						PH_TLL: begin
							topic_bytes = b;
							if (b + 32'd5 > decl_len) begin
								abandon_frame();
							end else begin
								topic_left = b;
								ph         = (b != 8'h00) ? PH_TOPIC : PH_MIDH;
							end
						end
						PH_TOPIC: begin
							push_deframed(KIND_TOPIC, b, 1'b1, 1'b0, 1'b0);
							topic_left = topic_left - 1'b1;
							if (topic_left == 8'h00) ph = PH_MIDH;
						end
						PH_MIDH: begin
							msg_id = {b, 8'h00};
							ph     = PH_MIDL;
						end
						PH_MIDL: begin
							msg_id = {msg_id[15:8], b};
							ph     = PH_PAYLOAD;
						end
						PH_PAYLOAD: push_deframed(KIND_PAYLOAD, b, 1'b1, 1'b1, 1'b0);
						default: abandon_frame();
					endcase
				end
			end
		endcase
		if (eob) begin
			if (!rejected && ph == PH_PAYLOAD && body_cnt == decl_len)
				push_deframed(KIND_ACCEPT, 8'h00, 1'b1, 1'b1, 1'b1);
			else
				push_deframed(KIND_REJECT, 8'h00, 1'b0, 1'b0, 1'b1);
			reset_parser();
		end
	endfunction

	function automatic void compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
		end
	endfunction

	function automatic void check_output();
		deframed_t want;
		if (deframed_q.size() == 0) begin
			mismatches++;
			$error("output transaction with nothing outstanding (kind %0d)", m_axis_tuser);
			return;
		end
		want = deframed_q.pop_front();
		compare_field("kind", want.kind, m_axis_tuser);
		compare_field("data", want.data, m_axis_tdata[7:0]);
		compare_field("frame_type", want.frame_type, m_axis_tdata[15:8]);
		compare_field("version", want.version, m_axis_tdata[23:16]);
		compare_field("message_id", want.message_id, m_axis_tdata[39:24]);
		compare_field("topic_length", want.topic_length, m_axis_tdata[47:40]);
		compare_field("payload_length", want.payload_length, m_axis_tdata[63:48]);
		compare_field("last", want.last, m_axis_tlast);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && s_axis_tready)
				parse_byte(byte_data, byte_last);
			if (m_axis_tvalid && out_ready)
				check_output();
			if ((byte_valid && s_axis_tready) || (m_axis_tvalid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	// output ready: random stalls, or a long hold-off on request
	initial begin
		@(posedge clk);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, sink_stalls ? 20 : 1)) @(posedge clk);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eob);
		if (source_gaps && $urandom_range(0, 9) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= b;
		byte_last  <= eob;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	task automatic send_buffer();
		for (int i = 0; i < rx_buf.size(); i++)
			send_byte(rx_buf[i], i == rx_buf.size() - 1);
	endtask

	task automatic drain_results();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (deframed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// declared length = 5 + topic + payload + adj, over at least nlen length bytes
	function automatic void build_frame(input logic [7:0] kind_byte, input int tlen,
			input int npay, input int adj, input int nlen);
		int decl;
		int need;
		int lb;
		decl = 5 + tlen + npay + adj;
		if (decl < 0) decl = 0;
		if (decl > 32'h0FFF_FFFF) decl = 32'h0FFF_FFFF;
		need = 1;
		while (need < MAX_LENGTH_BYTES && (decl >> (7 * need)) != 0)
			need++;
		if (nlen < need) nlen = need;
		rx_buf.delete();
		rx_buf.push_back(SYNC_BYTE);
		rx_buf.push_back(SYNC_BYTE);
		rx_buf.push_back(kind_byte);
		for (int i = nlen - 1; i >= 0; i--) begin
			lb = (decl >> (7 * i)) & 32'h7F;
			if (i != 0) lb = lb | 32'h80;
			rx_buf.push_back(lb[7:0]);
		end
		rx_buf.push_back(8'($urandom_range(0, 255)));
		rx_buf.push_back(8'($urandom_range(0, 255)));
		rx_buf.push_back(tlen[7:0]);
		repeat (tlen) rx_buf.push_back(8'($urandom_range(0, 255)));
		rx_buf.push_back(8'($urandom_range(0, 255)));
		rx_buf.push_back(8'($urandom_range(0, 255)));
		repeat (npay) rx_buf.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void make_random_buffer();
		int pick;
		int tlen;
		int npay;
		int adj;
		int cut;
		pick = $urandom_range(0, 99);
		tlen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
		npay = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 12);
		adj  = 0;
		if (pick >= 55 && pick < 63) adj = -$urandom_range(1, 3);
		else if (pick >= 63 && pick < 70) adj = $urandom_range(1, 3);
		else if (pick >= 70 && pick < 75) adj = -npay - $urandom_range(1, 5);
		build_frame(8'($urandom_range(0, 255)), tlen, npay, adj, $urandom_range(1, 4));
		if (pick >= 75 && pick < 83) begin
			cut    = $urandom_range(0, rx_buf.size() - 1);
			rx_buf = rx_buf[0:cut];
		end else if (pick >= 83 && pick < 90) begin
			rx_buf[$urandom_range(0, rx_buf.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (pick >= 90 && pick < 95) begin
			// length field that never terminates
			rx_buf.delete();
			rx_buf.push_back(SYNC_BYTE);
			rx_buf.push_back(SYNC_BYTE);
			rx_buf.push_back(8'($urandom_range(0, 255)));
			repeat (MAX_LENGTH_BYTES) rx_buf.push_back(8'h80 | 8'($urandom_range(0, 127)));
			repeat ($urandom_range(0, 5)) rx_buf.push_back(8'($urandom_range(0, 255)));
		end else if (pick >= 95) begin
			rx_buf.delete();
			if ($urandom_range(0, 1)) rx_buf.push_back(SYNC_BYTE);
			repeat ($urandom_range(1, 8)) rx_buf.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	task automatic test_frame_acceptance();
		rx_buf = '{8'hBB, 8'hBB, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_buffer();
		rx_buf = '{8'hBB, 8'hBB, 8'hFF, 8'h08, 8'hFF, 8'hFF, 8'h01, 8'h00,
			8'hFF, 8'hFF, 8'h00, 8'hFF};
		send_buffer();
		// padded three-byte length
		build_frame(8'hA5, 1, 2, 0, 3);
		send_buffer();
		drain_results();
	endtask

	task automatic test_sync_errors();
		rx_buf = '{8'h00};
		send_buffer();
		rx_buf = '{8'hBB, 8'h3A, 8'hBB};
		send_buffer();
		rx_buf = '{8'hBB};
		send_buffer();
		drain_results();
	endtask

	task automatic test_length_field();
		rx_buf = '{8'hBB, 8'hBB, 8'h01, 8'h80, 8'hFF, 8'h80, 8'h80, 8'h05, 8'h06};
		send_buffer();
		rx_buf = '{8'hBB, 8'hBB, 8'h01, 8'h81, 8'h82, 8'h83, 8'h84};
		send_buffer();
		// largest four-byte length, buffer far too short
		build_frame(8'h77, 0, 3, 32'h0FFF_FFFF - 8, 4);
		send_buffer();
		drain_results();
	endtask

	task automatic test_body_errors();
		// topic longer than declared length allows
		rx_buf = '{8'hBB, 8'hBB, 8'h20, 8'h05, 8'h01, 8'h00, 8'h01};
		send_buffer();
		// one payload byte more than declared
		rx_buf = '{8'hBB, 8'hBB, 8'h10, 8'h06, 8'h01, 8'h00, 8'h00, 8'h12, 8'h34,
			8'hAA, 8'hBB};
		send_buffer();
		// buffer ends inside the topic
		rx_buf = '{8'hBB, 8'hBB, 8'h30, 8'h08, 8'h02, 8'h00, 8'h02, 8'h41};
		send_buffer();
		build_frame(8'h44, 2, 3, 2, 1);
		send_buffer();
		build_frame(8'h5A, 255, 4, 0, 2);
		send_buffer();
		drain_results();
	endtask

	task automatic test_output_backpressure();
		sink_stalls  = 1'b0;
		hold_request = 1'b1;
		build_frame(8'h66, 12, 80, 0, 2);
		send_buffer();
		drain_results();
		sink_stalls = 1'b1;
	endtask

	task automatic test_random_traffic(input int n_bytes);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			make_random_buffer();
			send_buffer();
			if ($urandom_range(0, 30) == 0) drain_results();
		end
		drain_results();
	endtask

	initial begin
		reset_parser();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_frame_acceptance();
		test_sync_errors();
		test_length_field();
		test_body_errors();
		test_output_backpressure();
		test_random_traffic(800);
		source_gaps = 1'b0;
		sink_stalls = 1'b0;
		test_random_traffic(200);
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/svfd_pkg.sv
rtl/core/svfd_front.sv
rtl/core/svfd_queue.sv
rtl/core/svfd_back.sv
rtl/core/sync_varlen_frame_deframer.sv
test/tb_sync_varlen_frame_deframer.sv
